/* design/sups_pkg.sv */
package sups_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_ADDED  = 3'd0,
		ST_DUP    = 3'd1,
		ST_POPPED = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	localparam int unsigned DATA_W = 32;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic              ins;
		logic              pop;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

/* design/sups_cell.sv */
module sups_cell (
	input  logic                        clk,
	input  sups_pkg::cell_cmd_t         cmd,
	input  logic                        valid,
	input  logic                        below_gt,
	input  logic [sups_pkg::DATA_W-1:0] below_entry,
	input  logic [sups_pkg::DATA_W-1:0] above_entry,
	output logic [sups_pkg::DATA_W-1:0] entry,
	output logic                        gt,
	output logic                        eq
);
	import sups_pkg::*;

	logic [DATA_W-1:0] entry_q;

	// Compare the held entry against the broadcast value
	assign gt    = valid && (entry_q > cmd.value);
	assign eq    = valid && (entry_q == cmd.value);
	assign entry = entry_q;

	// Larger entries stay, the boundary cell takes the value, smaller ones move up
	always_ff @(posedge clk) begin
		if (cmd.ins && !gt) begin
			entry_q <= below_gt ? cmd.value : below_entry;
		end else if (cmd.pop) begin
			entry_q <= above_entry;
		end
	end

endmodule

/* design/sorted_unique_pointer_set.sv */
// A request is captured when it is accepted; its result is registered once the output is free to take it.
// No new request is accepted while an item is held (req_stall follows busy); the compare-and-shift
// step across all cells of the sorted chain is applied when the held item's result is registered.
// Cells hold entries in descending order, so a pop always takes the entry of cell 0.
// Reset (arst_n low) clears the entry count and the handshake state at once;
// cell contents are not reset and only cells below the count are ever compared or returned.
module sorted_unique_pointer_set #(
	parameter int unsigned CAPACITY = 64,
	localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        action,
	input  logic [sups_pkg::DATA_W-1:0] value,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [2:0]                  status,
	output logic [sups_pkg::DATA_W-1:0] popped_value,
	output logic [CW-1:0]               entry_count
);
	import sups_pkg::*;

	logic              busy_q;
	logic              act_s1;
	logic [DATA_W-1:0] value_s1;
	logic [CW-1:0]     count_q;
	logic              fire;
	logic              any_eq;
	logic              full;
	logic              empty;
	cell_cmd_t         cmd;
	status_t           status_d;
	logic [DATA_W-1:0] popped_d;
	logic [CW-1:0]     count_d;
	status_t           status_q;
	logic [DATA_W-1:0] popped_q;

	logic [DATA_W-1:0] entry_vec [CAPACITY];
	logic [CAPACITY-1:0] gt_vec;
	logic [CAPACITY-1:0] eq_vec;

	assign req_stall = busy_q;
	assign fire      = busy_q && (!rsp_valid || !rsp_stall);
	assign any_eq    = |eq_vec;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);

	// Decide the outcome of the held item
	always_comb begin
		status_d  = ST_ADDED;
		popped_d  = '0;
		count_d   = count_q;
		cmd.ins   = 1'b0;
		cmd.pop   = 1'b0;
		cmd.value = value_s1;
		if (act_s1) begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				status_d = ST_POPPED;
				popped_d = entry_vec[0];
				count_d  = count_q - CW'(1);
				cmd.pop  = fire;
			end
		end else if (any_eq) begin
			status_d = ST_DUP;
		end else if (full) begin
			status_d = ST_FULL;
		end else begin
			count_d = count_q + CW'(1);
			cmd.ins = fire;
		end
	end

	// Build the chain of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic              below_gt;
		logic [DATA_W-1:0] below_entry;
		logic [DATA_W-1:0] above_entry;

		if (i == 0) begin : g_first
			assign below_gt    = 1'b1;
			assign below_entry = value_s1;
		end else begin : g_mid
			assign below_gt    = gt_vec[i-1];
			assign below_entry = entry_vec[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign above_entry = entry_vec[i];
		end else begin : g_up
			assign above_entry = entry_vec[i+1];
		end

		sups_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.valid       (count_q > CW'(i)),
			.below_gt    (below_gt),
			.below_entry (below_entry),
			.above_entry (above_entry),
			.entry       (entry_vec[i]),
			.gt          (gt_vec[i]),
			.eq          (eq_vec[i])
		);
	end

	// Control: accept, process, hand off the result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rsp_valid <= 1'b0;
			count_q   <= '0;
		end else begin
			if (req_valid && !busy_q) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				rsp_valid <= 1'b1;
				count_q   <= count_d;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// Payload: capture the request and the result
	always_ff @(posedge clk) begin
		if (req_valid && !busy_q) begin
			act_s1   <= action;
			value_s1 <= value;
		end
		if (fire) begin
			status_q <= status_d;
			popped_q <= popped_d;
		end
	end

	assign status       = status_q;
	assign popped_value = popped_q;
	assign entry_count  = count_q;

endmodule

/* design/sups_checker.sv */
module sups_checker #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input logic [2:0]                  status,
	input logic [sups_pkg::DATA_W-1:0] popped_value,
	input logic [CW-1:0]               entry_count
);
	import sups_pkg::*;

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(entry_count))
		else $error("stalled result changed");

	// Only a pop returns a nonzero value
	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_POPPED) |-> popped_value == '0)
		else $error("popped value without pop");

	// Drop on full only when the store is at capacity
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL) |-> entry_count == CW'(CAPACITY))
		else $error("full status below capacity");

	// Empty pop leaves the store empty
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_EMPTY) |-> entry_count == '0)
		else $error("empty status with entries held");

	// Count never exceeds capacity
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> entry_count <= CW'(CAPACITY))
		else $error("entry count above capacity");

endmodule

bind sorted_unique_pointer_set sups_checker #(.CAPACITY(CAPACITY), .CW(CW)) u_sups_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.status       (status),
	.popped_value (popped_value),
	.entry_count  (entry_count)
);
